// File: sv/sopa_pkg.sv
// ----------------------------------------------------------------------------
// sopa_pkg
// Shared constants, codes and the periodicity table of the offset pool
// allocator.
// ----------------------------------------------------------------------------
package sopa_pkg;

  localparam int POOL_DEPTH  = 4096;
  localparam int NUM_PERIODS = 16;

  localparam int PTR_W    = $clog2(POOL_DEPTH);
  localparam int CNT_W    = $clog2(POOL_DEPTH + 1);
  localparam int PIDX_W   = $clog2(NUM_PERIODS);
  localparam int OFF_W    = 12;
  localparam int PERIOD_W = 12;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;

  localparam logic [PIDX_W-1:0] START_RESET = PIDX_W'(10);
  localparam logic [PIDX_W-1:0] PIDX_MAX    = PIDX_W'(NUM_PERIODS - 1);

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INC     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEC     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_LARGER  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_SMALLER = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_TABLE [NUM_PERIODS] = '{
    12'd2,   12'd4,   12'd5,   12'd8,   12'd10,  12'd16,   12'd20,   12'd32,
    12'd40,  12'd64,  12'd80,  12'd160, 12'd320, 12'd640,  12'd1280, 12'd2560
  };

  // Number of entries a refill writes: the period, capped at the pool depth.
  function automatic logic [CNT_W-1:0] fill_limit(input logic [PIDX_W-1:0] idx);
    logic [CNT_W-1:0] p;
    p = CNT_W'(PERIOD_TABLE[idx]);
    if (p > CNT_W'(POOL_DEPTH)) begin
      p = CNT_W'(POOL_DEPTH);
    end
    return p;
  endfunction

endpackage

// File: sv/srs_offset_pool_allocator.sv
// ----------------------------------------------------------------------------
// srs_offset_pool_allocator
// LIFO pool of free sounding-reference offsets with a stepped periodicity;
// one stack memory and a fill counter under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  command   | start / busy              | command, release_offset
//  result    | done (one-cycle strobe)   | status, granted_offset, period_now,
//            |                           | max_reached
//  config    | cfg_valid / cfg_ready     | start_period_index
//
//  Allocate from a non-empty pool: the strobe follows the transfer through the
//  read state (read of the stack memory) and the response state.
//  Release, allocate on an empty pool, failed steps, unused codes: the strobe
//  follows the transfer through the response state alone.
//  Increase, decrease, restart: the strobe follows a refill of P entries, P the
//  new period capped at pool depth; the fill counter writes one entry per cycle.
//  After reset the pool is filled with 0..79, with busy high throughout.
//  The receiver cannot stall; busy drops in the cycle the result is shown.
// ----------------------------------------------------------------------------
module srs_offset_pool_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sopa_pkg::CMD_W-1:0]     command,
  input  logic [sopa_pkg::OFF_W-1:0]     release_offset,
  output logic                           done,
  output logic [sopa_pkg::STAT_W-1:0]    status,
  output logic [sopa_pkg::OFF_W-1:0]     granted_offset,
  output logic [sopa_pkg::PERIOD_W-1:0]  period_now,
  output logic                           max_reached,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sopa_pkg::PIDX_W-1:0]    start_period_index
);
  import sopa_pkg::*;

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_FILL = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CNT_W-1:0]    fill_cnt;
  logic [CNT_W-1:0]    fill_lim;
  logic                fill_end;
  logic                pool_full;
  logic [PIDX_W-1:0]   period_index;
  logic [PIDX_W-1:0]   start_idx;
  logic [STAT_W-1:0]   st;
  logic [OFF_W-1:0]    grant;

  logic [OFF_W-1:0]    mem [POOL_DEPTH];
  logic [OFF_W-1:0]    rd_data;
  logic                mem_we;
  logic                mem_re;
  logic [PTR_W-1:0]    mem_addr;
  logic [OFF_W-1:0]    mem_wdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cnt_dec   = count - 1'b1;
  assign fill_end  = (fill_cnt == fill_lim - 1'b1);
  assign pool_full = (count >= CNT_W'(POOL_DEPTH));

  // single port: fill writes, release writes, allocate reads
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = count[PTR_W-1:0];
    mem_wdata = release_offset;
    case (state)
      S_INIT, S_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = fill_cnt[PTR_W-1:0];
        mem_wdata = fill_cnt[OFF_W-1:0];
      end
      S_IDLE: begin
        if (start) begin
          if (command == CMD_ALLOC && count != '0) begin
            mem_re   = 1'b1;
            mem_addr = cnt_dec[PTR_W-1:0];
          end else if (command == CMD_RELEASE && !pool_full) begin
            mem_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      fill_cnt     <= '0;
      fill_lim     <= fill_limit(START_RESET);
      period_index <= START_RESET;
      start_idx    <= START_RESET;
      count        <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        start_idx <= start_period_index;
      end
      case (state)
        S_INIT, S_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_end) begin
            count <= fill_lim;
            state <= (state == S_INIT) ? S_IDLE : S_RESP;
          end
        end
        S_IDLE: begin
          if (start) begin
            st    <= ST_OK;
            grant <= '0;
            state <= S_RESP;
            case (command)
              CMD_ALLOC: begin
                if (count == '0) begin
                  st <= ST_EMPTY;
                end else begin
                  count <= cnt_dec;
                  state <= S_READ;
                end
              end
              CMD_RELEASE: begin
                if (pool_full) begin
                  st <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              CMD_INC: begin
                count <= '0;
                if (period_index == PIDX_MAX) begin
                  st <= ST_NO_LARGER;
                end else begin
                  period_index <= period_index + 1'b1;
                  fill_lim     <= fill_limit(period_index + 1'b1);
                  fill_cnt     <= '0;
                  state        <= S_FILL;
                end
              end
              CMD_DEC: begin
                count <= '0;
                if (period_index == '0) begin
                  st <= ST_NO_SMALLER;
                end else begin
                  period_index <= period_index - 1'b1;
                  fill_lim     <= fill_limit(period_index - 1'b1);
                  fill_cnt     <= '0;
                  state        <= S_FILL;
                end
              end
              CMD_RESTART: begin
                period_index <= start_idx;
                fill_lim     <= fill_limit(start_idx);
                fill_cnt     <= '0;
                state        <= S_FILL;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          grant <= rd_data;
          state <= S_RESP;
        end
        S_RESP: begin
          done           <= 1'b1;
          status         <= st;
          granted_offset <= grant;
          period_now     <= PERIOD_TABLE[period_index];
          max_reached    <= (period_index == PIDX_MAX) && (count == '0);
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/sopa_checker.sv
// ----------------------------------------------------------------------------
// sopa_checker
// Port-level checks of the offset pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sopa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [sopa_pkg::STAT_W-1:0]    status,
  input logic [sopa_pkg::OFF_W-1:0]     granted_offset,
  input logic [sopa_pkg::PERIOD_W-1:0]  period_now,
  input logic                           max_reached
);
  import sopa_pkg::*;

  // reset starts the initial fill
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");

  a_empty_grant: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> granted_offset == '0)
    else $error("nonzero offset on empty pool");

  a_max_period: assert property (@(posedge clk) disable iff (rst)
    (done && max_reached) |-> period_now == PERIOD_TABLE[NUM_PERIODS-1])
    else $error("max reached below largest period");

endmodule

bind srs_offset_pool_allocator sopa_checker u_sopa_checker (.*);

// File: sim/tb_srs_offset_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_srs_offset_pool_allocator
// Self-checking bench for the offset pool allocator: a queue-fed command
// driver with its own model of the pool and the periodicity, a monitor that
// checks every strobed result in order, and a watchdog.
// ----------------------------------------------------------------------------
module tb_srs_offset_pool_allocator;
  import sopa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 40;
  localparam int DRAIN_CYCLES   = 12;

  typedef enum logic [1:0] {STEP_CMD, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic [CMD_W-1:0]   cmd;
    logic [OFF_W-1:0]   off;
    logic [PIDX_W-1:0]  cfg;
    int                 idle_pct;
  } pool_step_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [OFF_W-1:0]    granted;
    logic [PERIOD_W-1:0] period;
    logic                max_hit;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     command = '0;
  logic [OFF_W-1:0]     release_offset = '0;
  logic                 done;
  logic [STAT_W-1:0]    status;
  logic [OFF_W-1:0]     granted_offset;
  logic [PERIOD_W-1:0]  period_now;
  logic                 max_reached;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [PIDX_W-1:0]    start_period_index = '0;

  srs_offset_pool_allocator dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .command            (command),
    .release_offset     (release_offset),
    .done               (done),
    .status             (status),
    .granted_offset     (granted_offset),
    .period_now         (period_now),
    .max_reached        (max_reached),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .start_period_index (start_period_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // pool model
  logic [OFF_W-1:0]  free_offsets [POOL_DEPTH];
  int                pool_count;
  logic [PIDX_W-1:0] period_idx;
  logic [PIDX_W-1:0] restart_idx;

  pool_step_t    pending_steps [$];
  alloc_result_t expected_results [$];
  int            cmds_issued;
  int            results_seen;
  int            mismatches;
  int            quiet_cycles;
  int            cmd_total;

  function automatic void refill_pool();
    int fill;
    fill = int'(PERIOD_TABLE[period_idx]);
    if (fill > POOL_DEPTH) begin
      fill = POOL_DEPTH;
    end
    for (int i = 0; i < fill; i++) begin
      free_offsets[i] = OFF_W'(i);
    end
    pool_count = fill;
  endfunction

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] off,
                               output alloc_result_t res);
    res.status  = ST_OK;
    res.granted = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (pool_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pool_count--;
          res.granted = free_offsets[pool_count];
        end
      end
      CMD_RELEASE: begin
        if (pool_count >= POOL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          free_offsets[pool_count] = off;
          pool_count++;
        end
      end
      CMD_INC: begin
        pool_count = 0;
        if (period_idx == PIDX_MAX) begin
          res.status = ST_NO_LARGER;
        end else begin
          period_idx++;
          refill_pool();
        end
      end
      CMD_DEC: begin
        pool_count = 0;
        if (period_idx == '0) begin
          res.status = ST_NO_SMALLER;
        end else begin
          period_idx--;
          refill_pool();
        end
      end
      CMD_RESTART: begin
        period_idx = restart_idx;
        refill_pool();
      end
      default: ;
    endcase
    res.period  = PERIOD_TABLE[period_idx];
    res.max_hit = (period_idx == PIDX_MAX) && (pool_count == 0);
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
    end
  endtask

  function automatic void add_cmd(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] off,
                                  input int idle_pct);
    pool_step_t s;
    s.kind     = STEP_CMD;
    s.cmd      = cmd;
    s.off      = off;
    s.cfg      = '0;
    s.idle_pct = idle_pct;
    pending_steps = {pending_steps, s};
    cmd_total++;
  endfunction

  function automatic void add_cfg(input logic [PIDX_W-1:0] value);
    pool_step_t s;
    s.kind     = STEP_CFG;
    s.cmd      = CMD_ALLOC;
    s.off      = '0;
    s.cfg      = value;
    s.idle_pct = 0;
    pending_steps = {pending_steps, s};
  endfunction

  function automatic void add_drain();
    pool_step_t s;
    s.kind     = STEP_DRAIN;
    s.cmd      = CMD_ALLOC;
    s.off      = '0;
    s.cfg      = '0;
    s.idle_pct = 0;
    pending_steps = {pending_steps, s};
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 45) return CMD_ALLOC;
    if (r < 78) return CMD_RELEASE;
    if (r < 85) return CMD_INC;
    if (r < 92) return CMD_DEC;
    if (r < 97) return CMD_RESTART;
    return CMD_SPARE_FIRST + CMD_W'($urandom_range(CMD_SPARE_LAST - CMD_SPARE_FIRST));
  endfunction

  // driver: one command or config transfer at a time from the step queue
  always @(posedge clk) begin
    pool_step_t    head;
    alloc_result_t res;
    logic          drive_start;
    logic          drive_cfg;
    logic          idle_now;
    drive_start = 1'b0;
    drive_cfg   = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        apply_command(command, release_offset, res);
        expected_results = {expected_results, res};
        cmds_issued++;
        void'(pending_steps.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        restart_idx = start_period_index;
        void'(pending_steps.pop_front());
      end
      idle_now = !busy && !start && (cmds_issued == results_seen);
      if (pending_steps.size() > 0) begin
        head = pending_steps[0];
        case (head.kind)
          STEP_CMD: begin
            if (start && busy) begin
              drive_start = 1'b1;
            end else begin
              drive_start = ($urandom_range(99) >= head.idle_pct);
            end
          end
          STEP_CFG: begin
            drive_cfg = (cfg_valid && !cfg_ready) || (!cfg_valid && idle_now);
          end
          default: begin
            if (cmds_issued == results_seen) begin
              void'(pending_steps.pop_front());
            end
          end
        endcase
      end
    end
    start     <= drive_start;
    cfg_valid <= drive_cfg;
    if (drive_start) begin
      command        <= head.cmd;
      release_offset <= head.off;
    end else begin
      command        <= CMD_W'($urandom);
      release_offset <= OFF_W'($urandom);
    end
    if (drive_cfg) begin
      start_period_index <= head.cfg;
    end else begin
      start_period_index <= PIDX_W'($urandom);
    end
  end

  // monitor: the strobe cannot be held off, so a mid-cycle look is the transfer
  always @(negedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no command pending", status, 0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) flag_mismatch("status", status, want.status);
        if (granted_offset !== want.granted) begin
          flag_mismatch("granted_offset", granted_offset, want.granted);
        end
        if (period_now !== want.period) flag_mismatch("period_now", period_now, want.period);
        if (max_reached !== want.max_hit) begin
          flag_mismatch("max_reached", max_reached, want.max_hit);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle;
    int goal;
    int grp;
    int len;
    int cfg_plan [4];
    int idle_plan [4];
    cmds_issued  = 0;
    results_seen = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    cmd_total    = 0;
    restart_idx  = START_RESET;
    period_idx   = START_RESET;
    refill_pool();

    // directed: pool after reset holds 0..79, period 80
    add_cmd(CMD_ALLOC, '0, 0);
    add_cmd(CMD_RELEASE, '0, 0);
    add_cmd(CMD_RELEASE, '1, 0);          // offset above the period, pushed as is
    add_cmd(CMD_ALLOC, '0, 0);
    add_cmd(CMD_SPARE_FIRST, '1, 0);
    add_cmd(CMD_SPARE_FIRST + 3'd1, '0, 0);
    add_cmd(CMD_SPARE_LAST, '1, 0);
    add_cfg('0);
    add_cmd(CMD_RESTART, '0, 0);          // period 2
    add_cmd(CMD_ALLOC, '0, 0);
    add_cmd(CMD_ALLOC, '0, 0);
    add_cmd(CMD_ALLOC, '0, 0);            // empty pool
    add_cmd(CMD_DEC, '0, 0);              // no smaller period
    add_cmd(CMD_ALLOC, '0, 0);
    add_cmd(CMD_INC, '0, 0);
    add_cfg(PIDX_MAX);
    add_cmd(CMD_RESTART, '0, 0);          // period 2560
    add_cmd(CMD_INC, '0, 0);              // no larger period, pool emptied
    add_cmd(CMD_ALLOC, '0, 0);
    add_cmd(CMD_RELEASE, OFF_W'(2559), 0);
    add_cmd(CMD_ALLOC, '0, 0);
    add_cmd(CMD_DEC, '0, 0);
    add_cfg(START_RESET);
    add_cmd(CMD_RESTART, '0, 0);

    // release burst on top of the largest period, then pop some back
    add_cfg(PIDX_MAX);
    add_cmd(CMD_RESTART, '0, 0);
    for (int i = 0; i < 20; i++) begin
      add_cmd(CMD_RELEASE, OFF_W'($urandom), 0);
    end
    for (int i = 0; i < 6; i++) begin
      add_cmd(CMD_ALLOC, '0, 0);
    end

    cfg_plan  = '{3, 0, 15, 7};
    idle_plan = '{0, 77, 0, 13};
    for (int ph = 0; ph < 4; ph++) begin
      idle = idle_plan[ph];
      add_drain();
      add_cfg(ph == 3 ? PIDX_W'($urandom) : PIDX_W'(cfg_plan[ph]));
      add_cmd(CMD_RESTART, '0, idle);
      goal = cmd_total + 140;
      while (cmd_total < goal) begin
        grp = $urandom_range(99);
        if (grp < 40) begin
          for (int i = 0; i < 8; i++) begin
            add_cmd(pick_command(), OFF_W'($urandom), idle);
          end
        end else if (grp < 65) begin
          // period step, then enough allocates to often run dry
          case ($urandom_range(2))
            0: add_cmd(CMD_INC, '0, idle);
            1: add_cmd(CMD_DEC, '0, idle);
            default: add_cmd(CMD_RESTART, '0, idle);
          endcase
          len = $urandom_range(24, 1);
          for (int i = 0; i < len; i++) begin
            add_cmd(CMD_ALLOC, '0, idle);
          end
        end else if (grp < 85) begin
          for (int i = 0; i < 12; i++) begin
            add_cmd(i[0] ? CMD_RELEASE : CMD_ALLOC,
                    $urandom_range(1) ? OFF_W'($urandom) : OFF_W'($urandom_range(159)), idle);
          end
        end else if (grp < 95) begin
          add_drain();
          for (int i = 0; i < 4; i++) begin
            add_cmd(pick_command(), OFF_W'($urandom), idle);
          end
        end else begin
          add_cfg(PIDX_W'($urandom));
          add_cmd(CMD_RESTART, '0, idle);
        end
      end
    end

    @(negedge clk);
    while (pending_steps.size() != 0 || cmds_issued != results_seen) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      flag_mismatch("results never arrived", 0, expected_results.size());
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sopa_pkg.sv
sv/srs_offset_pool_allocator.sv
sv/sopa_checker.sv
sim/tb_srs_offset_pool_allocator.sv
